@@ rtl/core/kpvf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the micro-program of the Kalman filter.
package kpvf_pkg;

  localparam int RA_W = 5;
  localparam int PC_W = 7;

  typedef enum logic [3:0] {
    OP_LDC,
    OP_LDCFG,
    OP_LDZ,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIVDT,
    OP_RECIP,
    OP_OUT,
    OP_OUTC
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [RA_W-1:0] dst;
    logic [RA_W-1:0] a;
    logic [RA_W-1:0] b;
    logic            last;
  } instr_t;

  typedef struct packed {
    logic   start;
    logic   load;
    instr_t instr;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic meas_invalid;
    logic gap;
  } stat_t;

  typedef struct packed {
    logic [31:0] qpos;
    logic [31:0] qvel;
    logic [31:0] meas_noise;
    logic [31:0] fade;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_ISSUE,
    S_WAIT
  } ctrl_state_t;

  // Configuration register indexes.
  localparam logic [1:0] CIDX_QPOS = 2'd0;
  localparam logic [1:0] CIDX_QVEL = 2'd1;
  localparam logic [1:0] CIDX_MEAS = 2'd2;
  localparam logic [1:0] CIDX_FADE = 2'd3;

  // Constant selectors for OP_LDC.
  localparam logic [RA_W-1:0] K_ZERO    = 5'd0;
  localparam logic [RA_W-1:0] K_ONE     = 5'd1;
  localparam logic [RA_W-1:0] K_HUNDRED = 5'd2;
  localparam logic [RA_W-1:0] K_QUARTER = 5'd3;
  localparam logic [RA_W-1:0] K_HALF    = 5'd4;

  // Register file addresses.
  localparam logic [RA_W-1:0] R_POS = 5'd0;
  localparam logic [RA_W-1:0] R_VEL = 5'd1;
  localparam logic [RA_W-1:0] R_PP = 5'd2;
  localparam logic [RA_W-1:0] R_PV = 5'd3;
  localparam logic [RA_W-1:0] R_VP = 5'd4;
  localparam logic [RA_W-1:0] R_VV = 5'd5;
  localparam logic [RA_W-1:0] R_NIS = 5'd6;
  localparam logic [RA_W-1:0] R_DT = 5'd7;
  localparam logic [RA_W-1:0] R_DT2 = 5'd8;
  localparam logic [RA_W-1:0] R_DT3 = 5'd9;
  localparam logic [RA_W-1:0] R_DT4 = 5'd10;
  localparam logic [RA_W-1:0] R_XPP = 5'd11;
  localparam logic [RA_W-1:0] R_QV = 5'd12;
  localparam logic [RA_W-1:0] R_QP = 5'd13;
  localparam logic [RA_W-1:0] R_Q00 = 5'd14;
  localparam logic [RA_W-1:0] R_Q01 = 5'd15;
  localparam logic [RA_W-1:0] R_Q11 = 5'd16;
  localparam logic [RA_W-1:0] R_F00 = 5'd17;
  localparam logic [RA_W-1:0] R_F01 = 5'd18;
  localparam logic [RA_W-1:0] R_ALPHA = 5'd19;
  localparam logic [RA_W-1:0] R_P00 = 5'd20;
  localparam logic [RA_W-1:0] R_P01 = 5'd21;
  localparam logic [RA_W-1:0] R_P10 = 5'd22;
  localparam logic [RA_W-1:0] R_P11 = 5'd23;
  localparam logic [RA_W-1:0] R_Y = 5'd24;
  localparam logic [RA_W-1:0] R_S = 5'd25;
  localparam logic [RA_W-1:0] R_INV = 5'd26;
  localparam logic [RA_W-1:0] R_K0 = 5'd27;
  localparam logic [RA_W-1:0] R_K1 = 5'd28;
  localparam logic [RA_W-1:0] R_T0 = 5'd29;
  localparam logic [RA_W-1:0] R_T1 = 5'd30;

  // Program segment entry points.
  localparam logic [PC_W-1:0] PC_RST = 7'd0;
  localparam logic [PC_W-1:0] PC_RST_LAST = 7'd6;
  localparam logic [PC_W-1:0] PC_HOLD = 7'd7;
  localparam logic [PC_W-1:0] PC_SEED = 7'd8;
  localparam logic [PC_W-1:0] PC_SEED_LAST = 7'd10;
  localparam logic [PC_W-1:0] PC_MAIN = 7'd11;

  localparam logic [15:0] LONG_GAP_TICKS = 16'd50000;
  localparam logic [16:0] MEAS_MAX_Q8 = 17'd128000;

  function automatic instr_t mk(input op_t op, input logic [RA_W-1:0] dst,
                                input logic [RA_W-1:0] a, input logic [RA_W-1:0] b,
                                input logic last);
    instr_t i;
    i.op = op;
    i.dst = dst;
    i.a = a;
    i.b = b;
    i.last = last;
    return i;
  endfunction

  function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      7'd0: i = mk(OP_LDC, R_POS, K_ZERO, R_POS, 1'b0);
      7'd1: i = mk(OP_LDC, R_VEL, K_ZERO, R_POS, 1'b0);
      7'd2: i = mk(OP_LDC, R_PP, K_HUNDRED, R_POS, 1'b0);
      7'd3: i = mk(OP_LDC, R_PV, K_ZERO, R_POS, 1'b0);
      7'd4: i = mk(OP_LDC, R_VP, K_ZERO, R_POS, 1'b0);
      7'd5: i = mk(OP_LDC, R_VV, K_HUNDRED, R_POS, 1'b0);
      7'd6: i = mk(OP_LDC, R_NIS, K_ZERO, R_POS, 1'b1);
      7'd7: i = mk(OP_OUT, R_POS, R_POS, R_NIS, 1'b1);
      7'd8: i = mk(OP_LDZ, R_POS, R_POS, R_POS, 1'b0);
      7'd9: i = mk(OP_LDC, R_VEL, K_ZERO, R_POS, 1'b0);
      7'd10: i = mk(OP_OUT, R_POS, R_POS, R_NIS, 1'b1);
      7'd11: i = mk(OP_DIVDT, R_DT, R_POS, R_POS, 1'b0);
      7'd12: i = mk(OP_MUL, R_DT2, R_DT, R_DT, 1'b0);
      7'd13: i = mk(OP_MUL, R_DT3, R_DT2, R_DT, 1'b0);
      7'd14: i = mk(OP_MUL, R_DT4, R_DT2, R_DT2, 1'b0);
      7'd15: i = mk(OP_MUL, R_T0, R_VEL, R_DT, 1'b0);
      7'd16: i = mk(OP_ADD, R_XPP, R_POS, R_T0, 1'b0);
      7'd17: i = mk(OP_LDCFG, R_QV, 5'(CIDX_QVEL), R_POS, 1'b0);
      7'd18: i = mk(OP_LDCFG, R_QP, 5'(CIDX_QPOS), R_POS, 1'b0);
      7'd19: i = mk(OP_MUL, R_T0, R_QV, R_DT4, 1'b0);
      7'd20: i = mk(OP_LDC, R_T1, K_QUARTER, R_POS, 1'b0);
      7'd21: i = mk(OP_MUL, R_T0, R_T0, R_T1, 1'b0);
      7'd22: i = mk(OP_MUL, R_T1, R_QP, R_DT, 1'b0);
      7'd23: i = mk(OP_ADD, R_Q00, R_T0, R_T1, 1'b0);
      7'd24: i = mk(OP_MUL, R_T0, R_QV, R_DT3, 1'b0);
      7'd25: i = mk(OP_LDC, R_T1, K_HALF, R_POS, 1'b0);
      7'd26: i = mk(OP_MUL, R_Q01, R_T0, R_T1, 1'b0);
      7'd27: i = mk(OP_MUL, R_T0, R_QV, R_DT2, 1'b0);
      7'd28: i = mk(OP_MUL, R_T1, R_QV, R_DT, 1'b0);
      7'd29: i = mk(OP_ADD, R_Q11, R_T0, R_T1, 1'b0);
      7'd30: i = mk(OP_MUL, R_T0, R_VP, R_DT, 1'b0);
      7'd31: i = mk(OP_ADD, R_F00, R_PP, R_T0, 1'b0);
      7'd32: i = mk(OP_MUL, R_T0, R_VV, R_DT, 1'b0);
      7'd33: i = mk(OP_ADD, R_F01, R_PV, R_T0, 1'b0);
      7'd34: i = mk(OP_LDCFG, R_ALPHA, 5'(CIDX_FADE), R_POS, 1'b0);
      7'd35: i = mk(OP_MUL, R_T0, R_F01, R_DT, 1'b0);
      7'd36: i = mk(OP_ADD, R_T0, R_F00, R_T0, 1'b0);
      7'd37: i = mk(OP_MUL, R_T0, R_T0, R_ALPHA, 1'b0);
      7'd38: i = mk(OP_ADD, R_P00, R_T0, R_Q00, 1'b0);
      7'd39: i = mk(OP_MUL, R_T0, R_F01, R_ALPHA, 1'b0);
      7'd40: i = mk(OP_ADD, R_P01, R_T0, R_Q01, 1'b0);
      7'd41: i = mk(OP_MUL, R_T0, R_VV, R_DT, 1'b0);
      7'd42: i = mk(OP_ADD, R_T0, R_VP, R_T0, 1'b0);
      7'd43: i = mk(OP_MUL, R_T0, R_T0, R_ALPHA, 1'b0);
      7'd44: i = mk(OP_ADD, R_P10, R_T0, R_Q01, 1'b0);
      7'd45: i = mk(OP_MUL, R_T0, R_VV, R_ALPHA, 1'b0);
      7'd46: i = mk(OP_ADD, R_P11, R_T0, R_Q11, 1'b0);
      7'd47: i = mk(OP_LDZ, R_T0, R_POS, R_POS, 1'b0);
      7'd48: i = mk(OP_SUB, R_Y, R_T0, R_XPP, 1'b0);
      7'd49: i = mk(OP_LDCFG, R_T1, 5'(CIDX_MEAS), R_POS, 1'b0);
      7'd50: i = mk(OP_ADD, R_S, R_P00, R_T1, 1'b0);
      7'd51: i = mk(OP_RECIP, R_INV, R_S, R_POS, 1'b0);
      7'd52: i = mk(OP_MUL, R_K0, R_P00, R_INV, 1'b0);
      7'd53: i = mk(OP_MUL, R_K1, R_P10, R_INV, 1'b0);
      7'd54: i = mk(OP_MUL, R_T0, R_K0, R_Y, 1'b0);
      7'd55: i = mk(OP_ADD, R_POS, R_XPP, R_T0, 1'b0);
      7'd56: i = mk(OP_MUL, R_T0, R_K1, R_Y, 1'b0);
      7'd57: i = mk(OP_ADD, R_VEL, R_VEL, R_T0, 1'b0);
      7'd58: i = mk(OP_LDC, R_T1, K_ONE, R_POS, 1'b0);
      7'd59: i = mk(OP_SUB, R_T0, R_T1, R_K0, 1'b0);
      7'd60: i = mk(OP_MUL, R_PP, R_T0, R_P00, 1'b0);
      7'd61: i = mk(OP_MUL, R_PV, R_T0, R_P01, 1'b0);
      7'd62: i = mk(OP_MUL, R_T1, R_K1, R_P00, 1'b0);
      7'd63: i = mk(OP_SUB, R_VP, R_P10, R_T1, 1'b0);
      7'd64: i = mk(OP_MUL, R_T1, R_K1, R_P01, 1'b0);
      7'd65: i = mk(OP_SUB, R_VV, R_P11, R_T1, 1'b0);
      7'd66: i = mk(OP_MUL, R_T0, R_Y, R_Y, 1'b0);
      7'd67: i = mk(OP_MUL, R_NIS, R_T0, R_INV, 1'b0);
      7'd68: i = mk(OP_OUTC, R_POS, R_POS, R_NIS, 1'b1);
      default: i = mk(OP_LDC, R_T1, K_ZERO, R_POS, 1'b1);
    endcase
    return i;
  endfunction

endpackage

@@ rtl/core/kalman_position_velocity_filter.sv @@
`timescale 1ns / 1ps
// Two-state constant-velocity Kalman filter with fading memory, top level.
//
// Each input word produces exactly one output word. A word flagged invalid, a
// seeding word (the first after reset) and a full predict/update each run their
// own program segment; a seeding word after a gap over 5 s first runs the
// clearing program. A full predict/update runs on the single shared 24x24
// multiplier (29 products plus one reciprocal-constant multiplication that
// scales the interval) and the bit-serial divider, used once for the reciprocal
// of the innovation covariance. After reset the same clearing program loads the
// filter state before the first word is accepted. The finished word waits in an
// output register while the next word is taken; a word that is still waiting
// there stalls the next result. The user must write configuration only while
// the filter is idle; the block itself does not enforce this.
module kalman_position_velocity_filter import kpvf_pkg::*; #(
  parameter int STATE_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // meas[17:0], dt_ticks[33:18]
  input  logic        in_tuser,   // meas_invalid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // estimate[17:0], innovation_nis[49:18]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qpos       <= 32'd1677722;
      cfg_r.qvel       <= 32'd16777216;
      cfg_r.meas_noise <= 32'd16777216;
      cfg_r.fade       <= 32'd16777216;
    end else if (cfg_we) begin
      case (cfg_index)
        CIDX_QPOS: cfg_r.qpos       <= cfg_wdata;
        CIDX_QVEL: cfg_r.qvel       <= cfg_wdata;
        CIDX_MEAS: cfg_r.meas_noise <= cfg_wdata;
        default:   cfg_r.fade       <= cfg_wdata;
      endcase
    end
  end

  kpvf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  kpvf_dp #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg        (cfg_r),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ rtl/core/kpvf_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences the micro-program after reset and for each accepted word.
module kpvf_ctrl import kpvf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  ctrl_state_t     state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            first_r, first_nxt;
  logic            item_r, item_nxt;
  instr_t          cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ISSUE;
      pc_r    <= PC_RST;
      first_r <= 1'b1;
      item_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      first_r <= first_nxt;
      item_r  <= item_nxt;
    end
  end

  always_comb begin
    cur       = prog_rom(pc_r);
    state_nxt = state_r;
    pc_nxt    = pc_r;
    first_nxt = first_r;
    item_nxt  = item_r;
    in_tready = 1'b0;
    cmd.start = 1'b0;
    cmd.load  = 1'b0;
    cmd.instr = cur;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          item_nxt  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_ISSUE;
        if (st.meas_invalid) begin
          pc_nxt = PC_HOLD;
        end else if (st.gap) begin
          pc_nxt = PC_RST;
        end else if (first_r) begin
          pc_nxt = PC_SEED;
        end else begin
          pc_nxt = PC_MAIN;
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (st.done) begin
          if (!cur.last) begin
            pc_nxt    = pc_r + 7'd1;
            state_nxt = S_ISSUE;
          end else if (pc_r == PC_RST_LAST) begin
            first_nxt = 1'b1;
            if (item_r) begin
              pc_nxt    = PC_SEED;
              state_nxt = S_ISSUE;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            if (pc_r == PC_SEED_LAST) begin
              first_nxt = 1'b0;
            end
            item_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/kpvf_dp.sv @@
`timescale 1ns / 1ps
// Datapath: register file, shared multiplier, serial divider and output register.
module kpvf_dp import kpvf_pkg::*; #(
  parameter int STATE_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  input  cfg_t        cfg,
  input  logic [39:0] in_tdata,   // meas[17:0], dt_ticks[33:18]
  input  logic        in_tuser,   // meas_invalid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // estimate[17:0], innovation_nis[49:18]
);

  localparam int F = STATE_FRAC_BITS;
  localparam int NW = 2 * F + 1;
  localparam int QW = 2 * F + 2;
  localparam int CW = $clog2(2 * F + 3);
  localparam logic [47:0] FX_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FX_ONE = 48'(64'd1 << F);
  localparam logic [63:0] THR = (64'd1 << F) / 64'd1000000000;
  localparam logic [95:0] MUL_RND = 96'(64'd1 << (F - 1));
  localparam int Q8SH = F - 8;
  localparam logic [48:0] Q8RND = 49'((64'd1 << Q8SH) >> 1);
  localparam int NSH = F - 16;
  localparam logic [48:0] NRND = 49'((64'd1 << NSH) >> 1);
  localparam int CSH_L = (F >= 24) ? F - 24 : 0;
  localparam int CSH_R = (F >= 24) ? 0 : 24 - F;
  localparam logic [47:0] CRND = 48'((64'd1 << CSH_R) >> 1);
  // The interval is (ticks * 2^F + 5000) / 10000, taken as (that / 16) / 625
  // with an exact reciprocal multiplication for dividends below 2^(F+12).
  localparam logic [47:0] DT_M = 48'(((64'd1 << (F + 22)) + 64'd624) / 64'd625);

  logic [47:0] rf [32];

  op_t             op_r;
  logic [RA_W-1:0] dst_r, arg_r;
  logic            busy_r, busy_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [47:0]     opa_r, opb_r;
  logic [47:0]     ma_r, ma_nxt, mb_r, mb_nxt;
  logic [95:0]     acc_r, acc_nxt;
  logic [NW-1:0]   num_r, num_nxt;
  logic [47:0]     den_r, den_nxt, rem_r, rem_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic [47:0]     z_r;
  logic            inv_r;
  logic [15:0]     ticks_r;
  logic            out_valid_r, out_valid_nxt;
  logic [17:0]     est_r, est_nxt;
  logic [31:0]     nis_r, nis_nxt;
  logic            wr_en, done;
  logic [47:0]     wr_data;

  function automatic logic [47:0] mag(input logic [47:0] x);
    return x[47] ? 48'd0 - x : x;
  endfunction

  function automatic logic [47:0] reg_to_fx(input logic [31:0] v);
    logic [47:0] w;
    w = (48'(v) + CRND) >> CSH_R;
    return w << CSH_L;
  endfunction

  function automatic logic [47:0] sat49(input logic [48:0] s);
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'd0} : FX_MAX;
    end
    return s[47:0];
  endfunction

  assign st.meas_invalid = inv_r;
  assign st.gap = ticks_r > LONG_GAP_TICKS;
  assign st.done = done;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, nis_r, est_r};

  always_comb begin
    logic [1:0]    idx;
    logic [47:0]   pprod;
    logic [95:0]   rnd96;
    logic [95:0]   dtq;
    logic [47:0]   lim, res, dmag;
    logic          neg, ge, rbit;
    logic [48:0]   r2, m49;
    logic [QW-1:0] qr;
    logic [15:0]   tk;
    logic [47:0]   xs;

    wr_en         = 1'b0;
    wr_data       = opa_r;
    done          = 1'b0;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r + CW'(1);
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    acc_nxt       = acc_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    est_nxt       = est_r;
    nis_nxt       = nis_r;
    out_valid_nxt = out_valid_r;
    idx   = 2'(cnt_r - CW'(1));
    pprod = 48'(ma_r[idx[1]*24 +: 24]) * 48'(mb_r[idx[0]*24 +: 24]);
    neg   = opa_r[47] ^ opb_r[47];
    rnd96 = (acc_r + MUL_RND) >> F;
    dtq   = acc_r >> (F + 22);
    lim   = neg ? {1'b1, 47'd0} : FX_MAX;
    res   = (rnd96 > 96'(lim)) ? lim : rnd96[47:0];
    dmag  = mag(opa_r);
    r2    = {rem_r, num_r[NW-1]};
    ge    = r2 >= {1'b0, den_r};
    rbit  = {rem_r, 1'b0} >= {1'b0, den_r};
    qr    = q_r + QW'(rbit);
    tk    = (ticks_r == 16'd0) ? 16'd1 : ticks_r;
    xs    = (op_r == OP_OUTC && opa_r[47]) ? 48'd0 : opa_r;
    m49   = ({1'b0, mag(xs)} + Q8RND) >> Q8SH;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      case (op_r)
        OP_LDC: begin
          wr_en = 1'b1;
          done  = 1'b1;
          case (arg_r)
            K_ONE:     wr_data = FX_ONE;
            K_HUNDRED: wr_data = 48'(FX_ONE * 100);
            K_QUARTER: wr_data = FX_ONE >> 2;
            K_HALF:    wr_data = FX_ONE >> 1;
            default:   wr_data = 48'd0;
          endcase
        end
        OP_LDCFG: begin
          wr_en = 1'b1;
          done  = 1'b1;
          case (arg_r[1:0])
            CIDX_QPOS: wr_data = reg_to_fx(cfg.qpos);
            CIDX_QVEL: wr_data = reg_to_fx(cfg.qvel);
            CIDX_MEAS: wr_data = reg_to_fx(cfg.meas_noise);
            default:   wr_data = reg_to_fx(cfg.fade);
          endcase
        end
        OP_LDZ: begin
          wr_en   = 1'b1;
          done    = 1'b1;
          wr_data = z_r;
        end
        OP_ADD: begin
          wr_en   = 1'b1;
          done    = 1'b1;
          wr_data = sat49({opa_r[47], opa_r} + {opb_r[47], opb_r});
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          done    = 1'b1;
          wr_data = sat49({opa_r[47], opa_r} - {opb_r[47], opb_r});
        end
        OP_MUL, OP_DIVDT: begin
          if (cnt_r == CW'(0)) begin
            if (op_r == OP_DIVDT) begin
              ma_nxt = ((48'(tk) << F) + 48'd5000) >> 4;
              mb_nxt = DT_M;
            end else begin
              ma_nxt = mag(opa_r);
              mb_nxt = mag(opb_r);
            end
            acc_nxt = '0;
          end else if (cnt_r <= CW'(4)) begin
            case (idx)
              2'd0:    acc_nxt = acc_r + 96'(pprod);
              2'd3:    acc_nxt = acc_r + (96'(pprod) << 48);
              default: acc_nxt = acc_r + (96'(pprod) << 24);
            endcase
          end else begin
            wr_en = 1'b1;
            done  = 1'b1;
            if (op_r == OP_DIVDT) begin
              wr_data = dtq[47:0];
            end else begin
              wr_data = neg ? 48'd0 - res : res;
            end
          end
        end
        OP_RECIP: begin
          if (cnt_r == CW'(0)) begin
            rem_nxt = '0;
            q_nxt   = '0;
            num_nxt = NW'(1) << (NW - 1);
            den_nxt = dmag;
            if (64'(dmag) <= THR) begin
              wr_en   = 1'b1;
              done    = 1'b1;
              wr_data = 48'd0;
            end
          end else if (cnt_r <= CW'(NW)) begin
            num_nxt = num_r << 1;
            rem_nxt = ge ? 48'(r2 - {1'b0, den_r}) : r2[47:0];
            q_nxt   = {q_r[QW-2:0], ge};
          end else begin
            wr_en = 1'b1;
            done  = 1'b1;
            if (qr > QW'(FX_MAX)) begin
              qr = QW'(FX_MAX);
            end
            wr_data = opa_r[47] ? 48'd0 - qr[47:0] : qr[47:0];
          end
        end
        OP_OUT, OP_OUTC: begin
          if (!out_valid_r || out_tready) begin
            done          = 1'b1;
            out_valid_nxt = 1'b1;
            if (xs[47]) begin
              est_nxt = (m49 > 49'd131072) ? 18'h20000 : 18'(49'd0 - m49);
            end else begin
              est_nxt = (m49 > 49'd131071) ? 18'h1FFFF : m49[17:0];
            end
            if (opb_r[47] || opb_r == 48'd0) begin
              nis_nxt = 32'd0;
            end else begin
              m49 = ({1'b0, opb_r} + NRND) >> NSH;
              nis_nxt = (m49 > 49'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : m49[31:0];
            end
          end
        end
        default: done = 1'b1;
      endcase
    end
    if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf[dst_r] <= wr_data;
    end
    if (cmd.start) begin
      op_r  <= cmd.instr.op;
      dst_r <= cmd.instr.dst;
      arg_r <= cmd.instr.a;
      opa_r <= rf[cmd.instr.a];
      opb_r <= rf[cmd.instr.b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inv_r   <= in_tuser;
      ticks_r <= in_tdata[33:18];
      if (in_tdata[17]) begin
        z_r <= 48'd0;
      end else if (in_tdata[16:0] > MEAS_MAX_Q8) begin
        z_r <= 48'(MEAS_MAX_Q8) << (F - 8);
      end else begin
        z_r <= 48'(in_tdata[16:0]) << (F - 8);
      end
    end
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    est_r <= est_nxt;
    nis_r <= nis_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy_r)
    else $error("Operation finished while the datapath was idle.");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) cmd.start |-> !busy_r)
    else $error("Operation issued while the datapath was busy.");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(op_r == OP_OUT || op_r == OP_OUTC))
    else $error("Output word loaded outside an output operation.");

endmodule
